// File: hw/rtl/ctws_pkg.sv
// ----------------------------------------------------------------------------
// ctws_pkg: shared types and filter functions
// byte codes, per-byte state, result records and the single-pass step logic
// ----------------------------------------------------------------------------
package ctws_pkg;

   localparam int MaxRes = 3;
   localparam int CntW   = 2;

   localparam logic [7:0] ChNul   = 8'h00;
   localparam logic [7:0] ChBel   = 8'h07;
   localparam logic [7:0] ChTab   = 8'h09;
   localparam logic [7:0] ChLf    = 8'h0a;
   localparam logic [7:0] ChCr    = 8'h0d;
   localparam logic [7:0] ChSpace = 8'h20;
   localparam logic [7:0] ChQuote = 8'h22;
   localparam logic [7:0] ChHash  = 8'h23;
   localparam logic [7:0] ChStar  = 8'h2a;
   localparam logic [7:0] ChSlash = 8'h2f;

   typedef struct packed {
      logic       is_last;
      logic [7:0] in_byte;
   } ctws_req_type;

   typedef struct packed {
      logic       text_end;
      logic       run_last;
      logic       byte_valid;
      logic [7:0] out_byte;
   } ctws_rsp_type;

   typedef struct packed {
      logic in_block;
      logic star_seen;
      logic slash_held;
      logic in_hash_comment;
      logic in_quotes;
      logic space_held;
      logic stopped;
      logic line_start;
   } ctws_state_type;

   localparam ctws_state_type CtwsStateReset = '{
      in_block: 1'b0, star_seen: 1'b0, slash_held: 1'b0, in_hash_comment: 1'b0,
      in_quotes: 1'b0, space_held: 1'b0, stopped: 1'b0, line_start: 1'b1};

   typedef struct packed {
      ctws_state_type                  st;
      logic [CntW-1:0]                 n;
      ctws_rsp_type [MaxRes-1:0]       res;
   } ctws_acc_type;

   function automatic ctws_acc_type ctws_emit(ctws_acc_type a, logic [7:0] b);
      ctws_acc_type r;
      r = a;
      if (r.n < CntW'(MaxRes)) begin
         r.res[r.n] = '{text_end: 1'b0, run_last: 1'b0, byte_valid: 1'b1, out_byte: b};
         r.n        = r.n + CntW'(1);
      end
      return r;
   endfunction

   function automatic ctws_acc_type ctws_flush_space(ctws_acc_type a);
      ctws_acc_type r;
      r = a;
      if (r.st.space_held) begin
         r.st.space_held = 1'b0;
         r = ctws_emit(r, ChSpace);
      end
      return r;
   endfunction

   // line handling and quote-aware whitespace removal
   function automatic ctws_acc_type ctws_line_stage(ctws_acc_type a, logic [7:0] c);
      ctws_acc_type r;
      r = a;
      if (c == ChNul) begin
         r = ctws_flush_space(r);
         r.st.stopped = 1'b1;
      end else if (c == ChCr || c == ChLf) begin
         r = ctws_flush_space(r);
         r.st.in_hash_comment = 1'b0;
         r.st.line_start      = 1'b1;
      end else if (!r.st.in_hash_comment && !(r.st.line_start && c == ChSpace)) begin
         r.st.line_start = 1'b0;
         if (c == ChHash) begin
            r.st.space_held      = 1'b0;
            r.st.in_hash_comment = 1'b1;
         end else begin
            r = ctws_flush_space(r);
            if (c == ChQuote) begin
               r.st.in_quotes = !r.st.in_quotes;
               r = ctws_emit(r, c);
            end else if (!r.st.in_quotes && (c == ChSpace || c == ChTab)) begin
               r.st.space_held = r.st.space_held;
            end else if (r.st.in_quotes && c == ChSpace) begin
               r.st.space_held = 1'b1;
            end else begin
               r = ctws_emit(r, c);
            end
         end
      end
      return r;
   endfunction

   // block comment and bel removal
   function automatic ctws_acc_type ctws_block_stage(ctws_acc_type a, logic [7:0] c);
      ctws_acc_type r;
      logic         go;
      r  = a;
      go = 1'b1;
      if (r.st.in_block) begin
         go = 1'b0;
         if (r.st.star_seen && c == ChSlash) begin
            r.st.in_block  = 1'b0;
            r.st.star_seen = 1'b0;
         end else begin
            r.st.star_seen = (c == ChStar);
         end
      end else if (r.st.slash_held) begin
         r.st.slash_held = 1'b0;
         if (c == ChStar) begin
            r.st.in_block  = 1'b1;
            r.st.star_seen = 1'b1;
            go             = 1'b0;
         end else begin
            r = ctws_line_stage(r, ChSlash);
         end
      end
      if (go) begin
         if (c == ChSlash) begin
            r.st.slash_held = 1'b1;
         end else if (c != ChBel) begin
            r = ctws_line_stage(r, c);
         end
      end
      return r;
   endfunction

   // whole step for one request: results and next state
   function automatic ctws_acc_type ctws_step(ctws_state_type st, ctws_req_type q);
      ctws_acc_type r;
      r.st  = st;
      r.n   = '0;
      r.res = '0;
      if (!st.stopped) begin
         r = ctws_block_stage(r, q.in_byte);
      end
      if (q.is_last) begin
         if (!r.st.stopped && r.st.slash_held) begin
            r.st.slash_held = 1'b0;
            r = ctws_line_stage(r, ChSlash);
         end
         r = ctws_flush_space(r);
         if (r.n == '0) begin
            r.n = CntW'(1);
         end
         r.res[r.n - CntW'(1)].text_end = 1'b1;
         r.st = CtwsStateReset;
      end
      if (r.n != '0) begin
         r.res[r.n - CntW'(1)].run_last = 1'b1;
      end
      return r;
   endfunction

endpackage

// File: hw/rtl/ctws_in_stage.sv
// ----------------------------------------------------------------------------
// ctws_in_stage: request input register
// holds one request and passes it on when the filter stage takes it
// ----------------------------------------------------------------------------
module ctws_in_stage
   import ctws_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  ctws_req_type in_req,
   output logic         out_valid,
   input  logic         out_take,
   output ctws_req_type out_req
);

   logic         valid_ff, valid_in;
   ctws_req_type req_ff;

   assign in_ready = !valid_ff || out_take;
   assign valid_in = (in_valid && in_ready) || (valid_ff && !out_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         req_ff <= in_req;
      end
   end

   assign out_valid = valid_ff;
   assign out_req   = req_ff;

endmodule

// File: hw/rtl/ctws_filter.sv
// ----------------------------------------------------------------------------
// ctws_filter: filter state and result buffer
// runs one request through the step logic and drains up to three results
// ----------------------------------------------------------------------------
module ctws_filter
   import ctws_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_take,
   input  ctws_req_type req,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output ctws_rsp_type rsp
);

   ctws_state_type            state_ff;
   ctws_rsp_type [MaxRes-1:0] slot_ff, slot_in;
   logic [CntW-1:0]           cnt_ff, cnt_in;
   ctws_acc_type              step;
   logic                      fire;
   logic                      room;

   assign step      = ctws_step(state_ff, req);
   assign rsp_valid = (cnt_ff != '0);
   assign rsp       = slot_ff[0];
   assign fire      = rsp_valid && rsp_ready;
   // room when empty, or the last result leaves this cycle
   assign room      = (cnt_ff == '0) || (cnt_ff == CntW'(1) && rsp_ready);
   assign req_take  = req_valid && room;

   always_comb begin
      slot_in = slot_ff;
      cnt_in  = cnt_ff;
      if (req_take) begin
         slot_in = step.res;
         cnt_in  = step.n;
      end else if (fire) begin
         slot_in[0] = slot_ff[1];
         slot_in[1] = slot_ff[2];
         cnt_in     = cnt_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CtwsStateReset;
         cnt_ff   <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (req_take) begin
            state_ff <= step.st;
         end
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

endmodule

// File: hw/rtl/config_text_comment_whitespace_strip_core.sv
// ----------------------------------------------------------------------------
// config_text_comment_whitespace_strip_core: config text comment stripper
// removes block and hash comments, bel, line breaks and unquoted blanks
// ----------------------------------------------------------------------------
//
//   channel   dir   handshake              payload
//   req_*     in    req_tvalid/req_tready  tdata = raw byte, tlast = last byte of text
//   rsp_*     out   rsp_tvalid/rsp_tready  tdata = kept byte, tuser = valid/run last,
//                                          tlast = text end
//
// each request passes an input register, then the step logic into a three
// entry result buffer; its first result shows on rsp once the buffer has
// taken the request from the input register
// a request that yields several results holds the next request back until its
// last result leaves; the rate is one request per cycle while each yields at most one and rsp is ready
// reset clears the filter state (line start set) and empties both registers
// a stall on rsp holds the buffer head; the input register takes one more
// request and then holds req_tready low until the buffer can reload
//
module config_text_comment_whitespace_strip_core
   import ctws_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tlast,   // is_last
   // result channel
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic [1:0] rsp_tuser,   // [0] byte_valid, [1] run_last
   output logic       rsp_tlast    // text_end
);

   ctws_req_type req_in;
   ctws_req_type req_q;
   logic         req_q_valid;
   logic         req_q_take;
   ctws_rsp_type rsp;

   assign req_in = '{is_last: req_tlast, in_byte: req_tdata};

   // input register
   ctws_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_req    (req_in),
      .out_valid (req_q_valid),
      .out_take  (req_q_take),
      .out_req   (req_q)
   );

   // step logic, filter state and result buffer
   ctws_filter u_filter (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_q_valid),
      .req_take  (req_q_take),
      .req       (req_q),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   assign rsp_tdata = rsp.out_byte;
   assign rsp_tuser = {rsp.run_last, rsp.byte_valid};
   assign rsp_tlast = rsp.text_end;

endmodule

// File: hw/rtl/ctws_checker.sv
// ----------------------------------------------------------------------------
// ctws_checker: port checks for the comment stripper
// watches the request and result channels from the top level ports
// ----------------------------------------------------------------------------
module ctws_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic [1:0] rsp_tuser,
   input logic       rsp_tlast
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result changed under stall");

   // text end is always the last result of its request
   a_end_run: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser[1])
      else $error("text end without run last");

   // an empty result only marks the end of the text and carries zero
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tlast && rsp_tuser[1] && rsp_tdata == 8'h00)
      else $error("bad empty result");

   // a request is only held back while results are waiting
   a_req_block: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |-> rsp_tvalid)
      else $error("request blocked with no result pending");

   // nothing comes out right after reset
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind config_text_comment_whitespace_strip_core ctws_checker u_ctws_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// File: dv/tb_config_text_comment_whitespace_strip_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_config_text_comment_whitespace_strip_core: stream check of the text filter
// short directed texts for comment, quote, zero byte and end-of-text corners,
// then random texts built from comment and whitespace tokens plus raw noise,
// with random idle bursts on both channels; every result is compared against
// an in-bench model of the filter
// ----------------------------------------------------------------------------
module tb_config_text_comment_whitespace_strip_core
   import ctws_pkg::*;
;

   localparam int CycleLimit  = 200000;
   localparam int RandomBytes = 330;
   localparam int SettleTicks = 16;

   // one raw text byte plus its driving hints
   typedef struct packed {
      logic [7:0] data;
      logic       is_end;
      logic       drain;   // hold this request back until all results are in
      logic       calm;    // no idle bursts around this request
   } raw_req_type;

   // one filtered result as seen on the rsp channel
   typedef struct packed {
      logic [7:0] data;
      logic       kept;
      logic       run_end;
      logic       txt_end;
   } strip_out_type;

   // filter state tracked by the bench model
   typedef struct packed {
      logic in_cmt;       // inside slash-star comment
      logic star_pend;    // last comment byte was a star
      logic slash_pend;   // slash waiting for a possible star
      logic hash_skip;    // dropping bytes up to end of line
      logic quoted;       // inside double quotes
      logic blank_pend;   // quoted space waiting for a possible hash
      logic halted;       // zero byte seen, rest of text ignored
      logic line_head;    // nothing but spaces on this line so far
   } strip_state_type;

   localparam strip_state_type FreshState = '{
      in_cmt: 1'b0, star_pend: 1'b0, slash_pend: 1'b0, hash_skip: 1'b0,
      quoted: 1'b0, blank_pend: 1'b0, halted: 1'b0, line_head: 1'b1};

   // dut ports, all inputs known from time zero
   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = '0;
   logic       req_tlast  = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic       rsp_tlast;

   raw_req_type     raw_text_q[$];   // requests still to be driven
   strip_out_type   filtered_q[$];   // results the filter still owes us
   strip_state_type fs = FreshState;
   strip_out_type   step_buf[3];
   int              step_n;

   int n_req      = 0;
   int n_texts    = 0;
   int n_results  = 0;
   int n_kept     = 0;
   int n_drains   = 0;
   int fail_count = 0;
   int cycle_cnt  = 0;
   int send_gap   = 0;
   int stall_left = 0;
   logic calm_phase = 1'b0;

   config_text_comment_whitespace_strip_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // filter model
   // ------------------------------------------------------------------------

   // append one result of the current request, at most three per request
   function automatic void put_byte(logic [7:0] b, logic kept);
      if (step_n < 3) begin
         step_buf[step_n] = '{data: kept ? b : 8'h00, kept: kept,
                              run_end: 1'b0, txt_end: 1'b0};
         step_n++;
      end
   endfunction

   function automatic void release_blank();
      if (fs.blank_pend) begin
         fs.blank_pend = 1'b0;
         put_byte(ChSpace, 1'b1);
      end
   endfunction

   // line breaks, hash comments and quote-aware blank removal
   function automatic void line_filter(logic [7:0] c);
      if (c == ChNul) begin
         release_blank();
         fs.halted = 1'b1;
      end else if (c == ChCr || c == ChLf) begin
         release_blank();
         fs.hash_skip = 1'b0;
         fs.line_head = 1'b1;
      end else if (!fs.hash_skip && !(fs.line_head && c == ChSpace)) begin
         fs.line_head = 1'b0;
         if (c == ChHash) begin
            // a quoted space right before the hash goes away with it
            fs.blank_pend = 1'b0;
            fs.hash_skip  = 1'b1;
         end else begin
            release_blank();
            if (c == ChQuote) begin
               fs.quoted = !fs.quoted;
               put_byte(c, 1'b1);
            end else if (fs.quoted && c == ChSpace) begin
               fs.blank_pend = 1'b1;
            end else if (fs.quoted || !(c == ChSpace || c == ChTab)) begin
               put_byte(c, 1'b1);
            end
         end
      end
   endfunction

   // slash-star comments and bel removal
   function automatic void comment_filter(logic [7:0] c);
      logic pass;
      pass = 1'b1;
      if (fs.in_cmt) begin
         pass = 1'b0;
         if (fs.star_pend && c == ChSlash) begin
            fs.in_cmt    = 1'b0;
            fs.star_pend = 1'b0;
         end else begin
            fs.star_pend = (c == ChStar);
         end
      end else if (fs.slash_pend) begin
         fs.slash_pend = 1'b0;
         if (c == ChStar) begin
            // the opening star also counts toward the close
            fs.in_cmt    = 1'b1;
            fs.star_pend = 1'b1;
            pass         = 1'b0;
         end else begin
            line_filter(ChSlash);
         end
      end
      if (pass) begin
         if (c == ChSlash) begin
            fs.slash_pend = 1'b1;
         end else if (c != ChBel) begin
            line_filter(c);
         end
      end
   endfunction

   // work out the results of one accepted request and queue them
   function automatic void filter_byte(logic [7:0] c, logic is_end);
      step_n = 0;
      if (!fs.halted) begin
         comment_filter(c);
      end
      if (is_end) begin
         if (!fs.halted && fs.slash_pend) begin
            fs.slash_pend = 1'b0;
            line_filter(ChSlash);
         end
         release_blank();
         if (step_n == 0) begin
            put_byte(8'h00, 1'b0);
         end
         step_buf[step_n - 1].txt_end = 1'b1;
         fs = FreshState;
      end
      if (step_n > 0) begin
         step_buf[step_n - 1].run_end = 1'b1;
      end
      for (int i = 0; i < step_n; i++) begin
         filtered_q = {filtered_q, step_buf[i]};
      end
   endfunction

   // ------------------------------------------------------------------------
   // stimulus building
   // ------------------------------------------------------------------------

   function automatic void push_raw(logic [7:0] b, logic is_end,
                                    logic drain = 1'b0, logic calm = 1'b0);
      raw_req_type item;
      item       = '{data: b, is_end: is_end, drain: drain, calm: calm};
      raw_text_q = {raw_text_q, item};
   endfunction

   // one random text made of comment and whitespace tokens, or raw noise;
   // returns the number of bytes queued
   function automatic int add_text(int n_tok, logic noise, logic drain, logic calm);
      logic [7:0] txt[$];
      for (int k = 0; k < n_tok; k++) begin
         if (noise) begin
            txt = {txt, 8'($urandom_range(0, 255))};
         end else begin
            case ($urandom_range(0, 15))
               0, 1, 2: txt = {txt, 8'($urandom_range(8'h61, 8'h7a))};
               3: txt = {txt, 8'($urandom_range(8'h21, 8'h7e))};
               4, 5: txt = {txt, ChSpace};
               6: txt = {txt, ChTab};
               7: txt = {txt, ChQuote};
               8: txt = {txt, ChSlash, ChStar};
               9: txt = {txt, ChStar, ChSlash};
               10: txt = {txt, ChSlash};
               11: txt = {txt, ChStar};
               12: txt = {txt, ChHash};
               13: txt = {txt, (($urandom_range(0, 1) == 0) ? ChCr : ChLf)};
               14: txt = {txt, (($urandom_range(0, 3) == 0) ? ChNul : ChBel)};
               default: txt = {txt, 8'($urandom_range(0, 255))};
            endcase
         end
      end
      foreach (txt[i]) begin
         push_raw(txt[i], i == txt.size() - 1, drain && i == 0, calm);
      end
      return txt.size();
   endfunction

   // ------------------------------------------------------------------------
   // request driver: predicts on every accepted request
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : drive_req
      raw_req_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap   <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            filter_byte(req_tdata, req_tlast);
            n_req++;
            if (req_tlast) n_texts++;
         end
         // a request not yet taken stays on the bus untouched
         if (!req_tvalid || req_tready) begin
            if (send_gap != 0) begin
               send_gap   <= send_gap - 1;
               req_tvalid <= 1'b0;
            end else if (raw_text_q.size() == 0 ||
                         (raw_text_q[0].drain && filtered_q.size() != 0)) begin
               req_tvalid <= 1'b0;
            end else begin
               nxt = raw_text_q.pop_front();
               if (nxt.drain) n_drains++;
               req_tvalid <= 1'b1;
               req_tdata  <= nxt.data;
               req_tlast  <= nxt.is_end;
               calm_phase <= nxt.calm;
               if (!nxt.calm && $urandom_range(0, 5) == 0) begin
                  send_gap <= $urandom_range(1, 8);
               end
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // result monitor with random back-pressure
   // ------------------------------------------------------------------------
   function automatic void report_mismatch(string what, strip_out_type want,
                                           strip_out_type got);
      fail_count++;
      if (fail_count <= 10) begin
         $display("mismatch, result %0d: %s", n_results, what);
         $display("   expected byte %02h valid %b run_last %b text_end %b",
                  want.data, want.kept, want.run_end, want.txt_end);
         $display("   got      byte %02h valid %b run_last %b text_end %b",
                  got.data, got.kept, got.run_end, got.txt_end);
      end
   endfunction

   always @(posedge clock) begin : check_rsp
      strip_out_type got;
      strip_out_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = '{data: rsp_tdata, kept: rsp_tuser[0], run_end: rsp_tuser[1],
                    txt_end: rsp_tlast};
            n_results++;
            if (got.kept) n_kept++;
            if (filtered_q.size() == 0) begin
               report_mismatch("result with nothing outstanding", '0, got);
            end else begin
               want = filtered_q.pop_front();
               if (got.data !== want.data || got.kept !== want.kept ||
                   got.run_end !== want.run_end || got.txt_end !== want.txt_end) begin
                  report_mismatch("field differs", want, got);
               end
            end
         end
         // random stall bursts outside calm stretches
         if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            rsp_tready <= 1'b0;
         end else if (!calm_phase && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 7);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin : watchdog
      cycle_cnt++;
      if (cycle_cnt > CycleLimit) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_cnt, filtered_q.size());
         $display("tb_config_text_comment_whitespace_strip_core: FAIL");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // test sequence
   // ------------------------------------------------------------------------
   initial begin : run_test
      int   n_built;
      int   len;
      logic calm_txt;

      // slash-star-slash is a whole comment
      push_raw("a", 1'b0);
      push_raw(ChSlash, 1'b0);
      push_raw(ChStar, 1'b0);
      push_raw(ChSlash, 1'b0);
      push_raw("b", 1'b1);
      // line of blanks and a hash comment vanishes entirely
      push_raw(ChSpace, 1'b0);
      push_raw(ChHash, 1'b0);
      push_raw("c", 1'b0);
      push_raw(ChLf, 1'b0);
      push_raw("k", 1'b1);
      // quoted space before hash is dropped, text ends inside the comment
      push_raw(ChQuote, 1'b0);
      push_raw(ChSpace, 1'b0);
      push_raw(ChHash, 1'b1);
      // zero byte lets the held space out, then the rest is ignored
      push_raw(ChQuote, 1'b0);
      push_raw(ChSpace, 1'b0);
      push_raw(ChNul, 1'b0);
      push_raw("z", 1'b1);
      // end of text releases held space and held slash together
      push_raw(ChQuote, 1'b0);
      push_raw(ChSpace, 1'b0);
      push_raw(ChSlash, 1'b1);
      // bel, tab, cr and the top byte value
      push_raw(ChBel, 1'b0);
      push_raw(ChTab, 1'b0);
      push_raw(ChCr, 1'b0);
      push_raw(8'hff, 1'b1);
      // zero byte inside a block comment does not end the text
      push_raw(ChSlash, 1'b0);
      push_raw(ChStar, 1'b0);
      push_raw(ChNul, 1'b0);
      push_raw(ChStar, 1'b0);
      push_raw(ChSlash, 1'b1);

      // random texts; a calm stretch in the middle and a calm tail
      n_built = 0;
      for (int t = 0; n_built < RandomBytes; t++) begin
         calm_txt = (n_built >= 150 && n_built < 190) || n_built >= RandomBytes - 60;
         len = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 24) : $urandom_range(1, 8);
         n_built += add_text(len, $urandom_range(0, 7) == 0,
                             t == 0 || $urandom_range(0, 11) == 0, calm_txt);
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (raw_text_q.size() != 0 || req_tvalid || filtered_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (SettleTicks) @(posedge clock);

      if (filtered_q.size() != 0) begin
         fail_count++;
         $display("%0d expected results never arrived", filtered_q.size());
      end
      $display("covered %0d requests in %0d texts, %0d results (%0d kept bytes)",
               n_req, n_texts, n_results, n_kept);
      $display("sender held back %0d times until all results were in", n_drains);
      if (fail_count == 0) begin
         $display("tb_config_text_comment_whitespace_strip_core: PASS");
      end else begin
         $display("tb_config_text_comment_whitespace_strip_core: FAIL");
      end
      $finish;
   end

endmodule

// File: sim.f
hw/rtl/ctws_pkg.sv
hw/rtl/ctws_in_stage.sv
hw/rtl/ctws_filter.sv
hw/rtl/config_text_comment_whitespace_strip_core.sv
hw/rtl/ctws_checker.sv
dv/tb_config_text_comment_whitespace_strip_core.sv
